[design/ipv4_cidr_text_parser_unit_assert.svh]
// Assertion macros for the address text parser.
// Each check is sampled on the rising clock and is off while reset is held.
`ifndef IPV4_CIDR_TEXT_PARSER_UNIT_ASSERT_SVH
`define IPV4_CIDR_TEXT_PARSER_UNIT_ASSERT_SVH

// Clocked check with reset disable; the enclosing module supplies clk_i and rst_ni.
`define IPV4CP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: when the cause holds, the effect holds in the next cycle.
`define IPV4CP_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error(msg);

`endif

[design/ipv4cp_pkg.sv]
package ipv4cp_pkg;

  // Field widths.
  localparam int unsigned CharW   = 8;
  localparam int unsigned OctetW  = 8;
  localparam int unsigned AccumW  = 9;
  localparam int unsigned PrefixW = 6;
  localparam int unsigned ResultW = 40;

  // Limits.
  localparam logic [AccumW-1:0] AccumSat  = 9'd511;
  localparam logic [AccumW-1:0] OctetMax  = 9'd255;
  localparam logic [AccumW-1:0] PrefixMax = 9'd32;

  // Character codes.
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;

  typedef enum logic [3:0] {
    PH_NUM_WS   = 4'd0,
    PH_NUM_SIGN = 4'd1,
    PH_NUM_DIG  = 4'd2,
    PH_DOT_WS   = 4'd3,
    PH_SLASH_WS = 4'd4,
    PH_PRE_WS   = 4'd5,
    PH_PRE_SIGN = 4'd6,
    PH_PRE_DIG  = 4'd7,
    PH_DONE     = 4'd8
  } phase_e;

  typedef struct packed {
    logic [PrefixW-1:0] prefix_len;
    logic [OctetW-1:0]  octet_d;
    logic [OctetW-1:0]  octet_c;
    logic [OctetW-1:0]  octet_b;
    logic [OctetW-1:0]  octet_a;
    logic               addr_valid;
  } result_t;

  function automatic logic is_ws(input logic [CharW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Times ten plus the digit, saturating at the accumulator limit.
  function automatic logic [AccumW-1:0] add_digit(input logic [AccumW-1:0] acc,
                                                   input logic [CharW-1:0] c);
    logic [12:0] wide;
    logic [CharW-1:0] d;
    d    = c - ChZero;
    wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {5'b0, d};
    return (wide > {4'b0, AccumSat}) ? AccumSat : wide[AccumW-1:0];
  endfunction

  function automatic logic octet_bad(input logic [AccumW-1:0] acc, input logic neg);
    return (neg && (acc != '0)) || (acc > OctetMax);
  endfunction

  function automatic logic prefix_bad(input logic [AccumW-1:0] acc, input logic neg);
    return (neg && (acc != '0)) || (acc == '0) || (acc > PrefixMax);
  endfunction

endpackage

[design/ipv4_cidr_text_parser_unit.sv]
// Address text parser: takes an IPv4 address in dotted-decimal form, with an
// optional "/prefix" suffix, one character per item on the slave stream.
// tlast marks the final character of a text. On that item one result is
// produced on the master stream: a valid flag, four octets and the prefix
// length, all zero when the text is malformed. Items without tlast give no result.
// The result is registered and appears on the master side in the cycle after
// its final character is accepted. One character is taken per cycle while
// tready is high; the per-character work is a single state update with a
// times-ten accumulate between the parser registers and the result register.
// The result register decouples the two sides: input is taken while the
// result register is empty or being emptied in the same cycle. When the
// receiver stalls with a result pending, tready drops and the pending result
// holds until it is taken.
// Reset clears the parser to the start of a text and empties the result
// register. After each final character the parser returns to that state.
module ipv4_cidr_text_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] char_code
  input  logic        s_axis_tlast_i,  // last_char
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] addr_valid, [8:1] octet_a, [16:9] octet_b, [24:17] octet_c,
  // [32:25] octet_d, [38:33] prefix_len, [39] zero
  output logic [39:0] m_axis_tdata_o
);
  import ipv4cp_pkg::*;

  phase_e             phase_q, phase_d;
  logic [1:0]         idx_q, idx_d;
  logic [AccumW-1:0]  acc_q, acc_d;
  logic               neg_q, neg_d;
  logic [OctetW-1:0]  store_q [4];
  logic [OctetW-1:0]  store_d [4];
  logic               err_q, err_d;
  logic [PrefixW-1:0] prefix_q, prefix_d;

  logic               out_valid_q;
  result_t            res_q, res_d;

  logic [CharW-1:0]   ch;
  logic               ch_dig, ch_ws;
  logic [AccumW-1:0]  acc_next;
  logic               s_acc;

  assign ch       = s_axis_tdata_i[CharW-1:0];
  assign ch_dig   = is_digit(ch);
  assign ch_ws    = is_ws(ch);
  assign acc_next = add_digit(acc_q, ch);

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // Parser state update for one character.
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    store_d  = store_q;
    err_d    = err_q;
    prefix_d = prefix_q;
    if (!err_q) begin
      case (phase_q)
        PH_NUM_WS, PH_PRE_WS: begin
          if (ch_ws) begin
            phase_d = phase_q;
          end else if ((ch == ChPlus) || (ch == ChMinus)) begin
            neg_d   = (ch == ChMinus);
            phase_d = (phase_q == PH_NUM_WS) ? PH_NUM_SIGN : PH_PRE_SIGN;
          end else if (ch_dig) begin
            acc_d   = acc_next;
            phase_d = (phase_q == PH_NUM_WS) ? PH_NUM_DIG : PH_PRE_DIG;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_NUM_SIGN, PH_PRE_SIGN: begin
          if (ch_dig) begin
            acc_d   = acc_next;
            phase_d = (phase_q == PH_NUM_SIGN) ? PH_NUM_DIG : PH_PRE_DIG;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_NUM_DIG: begin
          if (ch_dig) begin
            acc_d = acc_next;
          end else if (octet_bad(acc_q, neg_q)) begin
            err_d = 1'b1;
          end else begin
            store_d[idx_q] = acc_q[OctetW-1:0];
            if (idx_q != 2'd3) begin
              if (ch == ChDot) begin
                idx_d   = idx_q + 2'd1;
                acc_d   = '0;
                neg_d   = 1'b0;
                phase_d = PH_NUM_WS;
              end else if (ch_ws) begin
                phase_d = PH_DOT_WS;
              end else begin
                err_d = 1'b1;
              end
            end else begin
              if (ch == ChSlash) begin
                acc_d   = '0;
                neg_d   = 1'b0;
                phase_d = PH_PRE_WS;
              end else if (ch_ws) begin
                phase_d = PH_SLASH_WS;
              end else begin
                err_d = 1'b1;
              end
            end
          end
        end
        PH_DOT_WS: begin
          if (ch == ChDot) begin
            idx_d   = idx_q + 2'd1;
            acc_d   = '0;
            neg_d   = 1'b0;
            phase_d = PH_NUM_WS;
          end else if (!ch_ws) begin
            err_d = 1'b1;
          end
        end
        PH_SLASH_WS: begin
          if (ch == ChSlash) begin
            acc_d   = '0;
            neg_d   = 1'b0;
            phase_d = PH_PRE_WS;
          end else if (!ch_ws) begin
            err_d = 1'b1;
          end
        end
        PH_PRE_DIG: begin
          if (ch_dig) begin
            acc_d = acc_next;
          end else begin
            if (prefix_bad(acc_q, neg_q)) begin
              err_d = 1'b1;
            end else begin
              prefix_d = acc_q[PrefixW-1:0];
            end
            phase_d = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_d = PH_DONE;
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end
  end

  // Verdict at the end of the text, taken from the updated state.
  always_comb begin
    res_d = '0;
    if (!err_d) begin
      case (phase_d)
        PH_NUM_DIG: begin
          if ((idx_d == 2'd3) && !octet_bad(acc_d, neg_d)) begin
            res_d.addr_valid = 1'b1;
            res_d.octet_d    = acc_d[OctetW-1:0];
          end
        end
        PH_PRE_DIG: begin
          if (!prefix_bad(acc_d, neg_d)) begin
            res_d.addr_valid = 1'b1;
            res_d.octet_d    = store_d[3];
            res_d.prefix_len = acc_d[PrefixW-1:0];
          end
        end
        PH_DONE: begin
          res_d.addr_valid = 1'b1;
          res_d.octet_d    = store_d[3];
          res_d.prefix_len = prefix_d;
        end
        default: begin
          res_d.addr_valid = 1'b0;
        end
      endcase
      if (res_d.addr_valid) begin
        res_d.octet_a = store_d[0];
        res_d.octet_b = store_d[1];
        res_d.octet_c = store_d[2];
      end
    end
  end

  // Parser registers; the final character of a text returns them to the start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_NUM_WS;
      idx_q    <= '0;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      err_q    <= 1'b0;
      prefix_q <= '0;
      for (int i = 0; i < 4; i++) begin
        store_q[i] <= '0;
      end
    end else if (s_acc) begin
      if (s_axis_tlast_i) begin
        phase_q  <= PH_NUM_WS;
        idx_q    <= '0;
        acc_q    <= '0;
        neg_q    <= 1'b0;
        err_q    <= 1'b0;
        prefix_q <= '0;
        for (int i = 0; i < 4; i++) begin
          store_q[i] <= '0;
        end
      end else begin
        phase_q  <= phase_d;
        idx_q    <= idx_d;
        acc_q    <= acc_d;
        neg_q    <= neg_d;
        err_q    <= err_d;
        prefix_q <= prefix_d;
        store_q  <= store_d;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc && s_axis_tlast_i) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (s_acc && s_axis_tlast_i) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, res_q};

`include "ipv4_cidr_text_parser_unit_assert.svh"

  `IPV4CP_ASSERT(a_invalid_zero, (out_valid_q && !res_q.addr_valid) |-> ((res_q.octet_a == '0) && (res_q.octet_b == '0) && (res_q.octet_c == '0) && (res_q.octet_d == '0) && (res_q.prefix_len == '0)), "invalid result carries nonzero payload")
  `IPV4CP_ASSERT(a_prefix_range, (out_valid_q && res_q.addr_valid) |-> (res_q.prefix_len <= PrefixMax[PrefixW-1:0]), "prefix length above limit")
  `IPV4CP_ASSERT_NEXT(a_no_spurious, s_acc && !s_axis_tlast_i && !(out_valid_q && !m_axis_tready_i), !out_valid_q, "result without final character")
  `IPV4CP_ASSERT_NEXT(a_restart, s_acc && s_axis_tlast_i, (phase_q == PH_NUM_WS) && (idx_q == '0) && (acc_q == '0) && !err_q, "parser not restarted after text")
  `IPV4CP_ASSERT_NEXT(a_err_sticky, err_q && !(s_acc && s_axis_tlast_i), err_q, "error cleared inside a text")

endmodule
